// ===== rtl/core/tpc_pkg.sv =====
// Shared widths, register indexes, pipeline beat types and the divider step for the profile core.
`default_nettype none
package tpc_pkg;

	localparam int RATE_W  = 24;
	localparam int STEP_W  = 24;
	localparam int DELTA_W = 15;
	localparam int FAC_W   = 17;
	localparam int TPS_W   = 10;
	localparam int IA_W    = 32;
	localparam int CFG_W   = 32;
	localparam int SQ_W    = 2 * RATE_W;
	// quotient bits resolved by the cell row, one bit per cell
	localparam int QW      = 25;
	localparam int RAMP_W  = QW + 1;
	// widest divisor: four times the intersection acceleration
	localparam int DEN_W   = IA_W + 2;
	localparam int MNUM_W  = IA_W + STEP_W + 2;

	localparam logic [FAC_W-1:0]  Q_ONE    = FAC_W'(65536);
	localparam logic [RAMP_W-1:0] RAMP_BIG = RAMP_W'(1) << QW;

	// configuration register indexes
	localparam logic REG_TICKS  = 1'b0;
	localparam logic REG_IACCEL = 1'b1;

	typedef struct packed {
		logic [DEN_W-1:0] den;
		logic [DEN_W-1:0] rem;
		logic [QW-1:0]    qd;
	} lane_t;

	typedef struct packed {
		logic [STEP_W-1:0] steps;
		logic [RATE_W-1:0] ir;
		logic [RATE_W-1:0] fr;
		logic              err;
		logic              acc_ovf;
		logic              dec_ovf;
		logic              m_zero;
		logic              m_full;
	} side_t;

	typedef struct packed {
		logic  valid;
		side_t side;
		lane_t acc;
		lane_t dec;
		lane_t mp;
	} cell_t;

	// one restoring division step: shift in the next dividend bit, subtract if it fits
	function automatic lane_t div_step(input lane_t l);
		lane_t        r;
		logic [DEN_W:0] t;
		logic         ge;
		t     = {l.rem, l.qd[QW-1]};
		ge    = (t >= {1'b0, l.den});
		r.den = l.den;
		r.rem = ge ? DEN_W'(t - {1'b0, l.den}) : t[DEN_W-1:0];
		r.qd  = {l.qd[QW-2:0], ge};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tpc_front.sv =====
// Front pipeline: rate scaling, per-minute acceleration, squares and divider setup.
`default_nettype none
module tpc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [tpc_pkg::STEP_W-1:0]  step_count,
	input  wire logic [tpc_pkg::RATE_W-1:0]  nominal_rate,
	input  wire logic [tpc_pkg::DELTA_W-1:0] rate_delta,
	input  wire logic [tpc_pkg::FAC_W-1:0]   entry_factor,
	input  wire logic [tpc_pkg::FAC_W-1:0]   exit_factor,
	input  wire logic [tpc_pkg::TPS_W-1:0]   ticks,
	input  wire logic [tpc_pkg::IA_W-1:0]    iaccel,
	output tpc_pkg::cell_t                  o
);
	import tpc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [STEP_W-1:0]        steps_s1, steps_s2, steps_s3, steps_s4;
	logic [RATE_W-1:0]        n_s1, n_s2;
	logic [RATE_W+FAC_W-1:0]  prod_i_s1, prod_f_s1;
	logic [DELTA_W+TPS_W-1:0] dt_s1;
	logic [RATE_W-1:0]        ir_s2, fr_s2, ir_s3, fr_s3, ir_s4, fr_s4;
	logic [DELTA_W+TPS_W+5:0] apm_s2;
	logic [SQ_W-1:0]          nn_s3, ii_s3, ff_s3;
	logic [IA_W+STEP_W-1:0]   bs_s3;
	logic [DELTA_W+TPS_W+6:0] den2_s3, den2_s4;
	logic [DEN_W-1:0]         den4_s3, den4_s4;
	logic                     err_s3, err_s4, bz_s3, bz_s4;
	logic [SQ_W-1:0]          anum_s4, dnum_s4;
	logic [MNUM_W:0]          sm_s4;

	logic [FAC_W-1:0]         fe, ff;
	logic [RATE_W+FAC_W-1:0]  sum_i, sum_f;
	cell_t                    nxt, pay_s5;

	// factors saturate at 1.0
	assign fe = (entry_factor > Q_ONE) ? Q_ONE : entry_factor;
	assign ff = (exit_factor > Q_ONE) ? Q_ONE : exit_factor;
	// ceiling of the product with the Q1.16 factor
	assign sum_i = prod_i_s1 + (RATE_W+FAC_W)'(16'hFFFF);
	assign sum_f = prod_f_s1 + (RATE_W+FAC_W)'(16'hFFFF);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: rate products, rate delta times ticks
	always_ff @(posedge clk) begin
		steps_s1  <= step_count;
		n_s1      <= nominal_rate;
		prod_i_s1 <= nominal_rate * fe;
		prod_f_s1 <= nominal_rate * ff;
		dt_s1     <= rate_delta * ticks;
	end

	// stage 2: scaled rates, per-minute acceleration (x60 = x64 - x4)
	always_ff @(posedge clk) begin
		steps_s2 <= steps_s1;
		n_s2     <= n_s1;
		ir_s2    <= sum_i[RATE_W+15:16];
		fr_s2    <= sum_f[RATE_W+15:16];
		apm_s2   <= {dt_s1, 6'b0} - {4'b0, dt_s1, 2'b0};
	end

	// stage 3: squares and the meeting-point product
	always_ff @(posedge clk) begin
		steps_s3 <= steps_s2;
		ir_s3    <= ir_s2;
		fr_s3    <= fr_s2;
		nn_s3    <= n_s2 * n_s2;
		ii_s3    <= ir_s2 * ir_s2;
		ff_s3    <= fr_s2 * fr_s2;
		bs_s3    <= iaccel * steps_s2;
		den2_s3  <= {apm_s2, 1'b0};
		err_s3   <= (apm_s2 == '0);
		bz_s3    <= (iaccel == '0);
		den4_s3  <= {iaccel, 2'b00};
	end

	// stage 4: ramp numerators and the signed meeting numerator
	always_ff @(posedge clk) begin
		steps_s4 <= steps_s3;
		ir_s4    <= ir_s3;
		fr_s4    <= fr_s3;
		anum_s4  <= nn_s3 - ii_s3;
		dnum_s4  <= nn_s3 - ff_s3;
		sm_s4    <= {2'b0, bs_s3, 1'b0} + (MNUM_W+1)'(ff_s3) - (MNUM_W+1)'(ii_s3);
		den2_s4  <= den2_s3;
		den4_s4  <= den4_s3;
		err_s4   <= err_s3;
		bz_s4    <= bz_s3;
	end

	// stage 5: range checks and divider lane setup
	always_comb begin
		logic                pos;
		logic [MNUM_W-1:0]   mn;
		nxt              = '0;
		nxt.valid        = v_s4;
		nxt.side.steps   = steps_s4;
		nxt.side.ir      = ir_s4;
		nxt.side.fr      = fr_s4;
		nxt.side.err     = err_s4;
		nxt.side.acc_ovf = ({9'b0, anum_s4} >= {den2_s4, 25'b0});
		nxt.side.dec_ovf = ({9'b0, dnum_s4} >= {den2_s4, 25'b0});
		pos              = !sm_s4[MNUM_W] && (sm_s4 != '0);
		mn               = sm_s4[MNUM_W-1:0];
		nxt.side.m_zero  = !pos;
		nxt.side.m_full  = bz_s4 || ({1'b0, mn} >= {den4_s4, 25'b0});
		nxt.acc.den      = DEN_W'(den2_s4);
		nxt.dec.den      = DEN_W'(den2_s4);
		nxt.mp.den       = den4_s4;
		if (!nxt.side.acc_ovf) begin
			nxt.acc.rem = DEN_W'(anum_s4[SQ_W-1:QW]);
			nxt.acc.qd  = anum_s4[QW-1:0];
		end
		if (!nxt.side.dec_ovf) begin
			nxt.dec.rem = DEN_W'(dnum_s4[SQ_W-1:QW]);
			nxt.dec.qd  = dnum_s4[QW-1:0];
		end
		if (pos && !nxt.side.m_full) begin
			nxt.mp.rem = DEN_W'(mn[MNUM_W-1:QW]);
			nxt.mp.qd  = mn[QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		pay_s5 <= nxt;
	end

	always_comb begin
		o       = pay_s5;
		o.valid = v_s5;
	end

endmodule
`default_nettype wire

// ===== rtl/core/tpc_cell.sv =====
// One divider cell: resolves one quotient bit of each of the three divisions.
`default_nettype none
module tpc_cell (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire tpc_pkg::cell_t d,
	output tpc_pkg::cell_t q
);
	import tpc_pkg::*;

	logic  vld_q;
	cell_t pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= d.valid;
		end
	end

	// step all three lanes, pass the sideband along
	always_ff @(posedge clk) begin
		pay_q.valid <= d.valid;
		pay_q.side  <= d.side;
		pay_q.acc   <= div_step(d.acc);
		pay_q.dec   <= div_step(d.dec);
		pay_q.mp    <= div_step(d.mp);
	end

	always_comb begin
		q       = pay_q;
		q.valid = vld_q;
	end

endmodule
`default_nettype wire

// ===== rtl/core/trapezoid_profile_calculator_core.sv =====
// Top level: config registers, front pipeline, divider cell row and result stage.
//
// Usage: pulse start with one motion block on step_count, nominal_rate,
// rate_delta, entry_factor and exit_factor; the beat is taken at that edge.
// busy is always low, so a new block may be started in every cycle.
// At the end of the pipeline done is high for one cycle with entry_rate,
// exit_rate, accel_until, decel_after and error on the result ports.
// Throughput is one block per cycle. The pipeline is five front stages
// (factor products, rate scaling, squares, numerators, range checks), a row
// of 25 divider cells that each resolve one quotient bit of the accelerate,
// decelerate and ramp-meeting divisions, and one result register.
// Config: cfg_we writes cfg_wdata to register cfg_idx (0 ticks_per_sec,
// 1 intersect_accel); write only while no block is in flight.
// Reset clears all valid bits and loads ticks_per_sec 100 and
// intersect_accel 1000000. The receiver takes every result as it comes.
`default_nettype none
module trapezoid_profile_calculator_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_idx,
	input  wire logic [tpc_pkg::CFG_W-1:0]   cfg_wdata,
	input  wire logic [tpc_pkg::STEP_W-1:0]  step_count,
	input  wire logic [tpc_pkg::RATE_W-1:0]  nominal_rate,
	input  wire logic [tpc_pkg::DELTA_W-1:0] rate_delta,
	input  wire logic [tpc_pkg::FAC_W-1:0]   entry_factor,
	input  wire logic [tpc_pkg::FAC_W-1:0]   exit_factor,
	output logic                            done,
	output logic [tpc_pkg::RATE_W-1:0]       entry_rate,
	output logic [tpc_pkg::RATE_W-1:0]       exit_rate,
	output logic [tpc_pkg::STEP_W-1:0]       accel_until,
	output logic [tpc_pkg::STEP_W-1:0]       decel_after,
	output logic                            error
);
	import tpc_pkg::*;

	localparam int LAT = 5 + QW + 1;

	logic [TPS_W-1:0] ticks_q;
	logic [IA_W-1:0]  iaccel_q;
	cell_t            link [0:QW];

	logic [RAMP_W-1:0] acc_v, dec_v, mq;
	logic [STEP_W+3:0] cruise;
	logic [STEP_W-1:0] mp, acc_o, dec_o;
	cell_t             c;

	assign busy = 1'b0;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= TPS_W'(100);
			iaccel_q <= IA_W'(1000000);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TICKS:  ticks_q  <= cfg_wdata[TPS_W-1:0];
				REG_IACCEL: iaccel_q <= cfg_wdata[IA_W-1:0];
				default:    ;
			endcase
		end
	end

	tpc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.step_count   (step_count),
		.nominal_rate (nominal_rate),
		.rate_delta   (rate_delta),
		.entry_factor (entry_factor),
		.exit_factor  (exit_factor),
		.ticks        (ticks_q),
		.iaccel       (iaccel_q),
		.o            (link[0])
	);

	// divider cell row
	for (genvar i = 0; i < QW; i++) begin : g_cell
		tpc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (link[i]),
			.q      (link[i+1])
		);
	end

	// ramp lengths, cruise sign and ramp meeting point
	always_comb begin
		c     = link[QW];
		acc_v = c.side.acc_ovf ? RAMP_BIG : ({1'b0, c.acc.qd} + RAMP_W'(|c.acc.rem));
		dec_v = c.side.dec_ovf ? RAMP_BIG : {1'b0, c.dec.qd};
		if (c.side.err) begin
			acc_v = '0;
			dec_v = '0;
		end
		cruise = {4'b0, c.side.steps} - {2'b0, acc_v} - {2'b0, dec_v};
		mq     = {1'b0, c.mp.qd} + RAMP_W'(|c.mp.rem);
		if (c.side.m_zero) begin
			mp = '0;
		end else if (c.side.m_full || (mq > {2'b0, c.side.steps})) begin
			mp = c.side.steps;
		end else begin
			mp = mq[STEP_W-1:0];
		end
		if (cruise[STEP_W+3]) begin
			acc_o = mp;
			dec_o = mp;
		end else begin
			acc_o = acc_v[STEP_W-1:0];
			dec_o = c.side.steps - dec_v[STEP_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= c.valid;
		end
	end

	always_ff @(posedge clk) begin
		entry_rate  <= c.side.ir;
		exit_rate   <= c.side.fr;
		accel_until <= acc_o;
		decel_after <= dec_o;
		error       <= c.side.err;
	end

	// a result beat always traces back to a start beat
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result beat without a matching start");

	// acceleration never ends after deceleration begins
	a_ramp_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (accel_until <= decel_after))
		else $error("accel_until beyond decel_after");

	// no acceleration when the ramp rate is zero
	a_err_no_accel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (accel_until == '0))
		else $error("accel_until nonzero with error set");

endmodule
`default_nettype wire
